// ----- sv/rcs_pkg.sv -----
// ---------------------------------------------------------------------------
// rcs_pkg: shared types for the RIFF chunk scanner
// Item structs, event kinds, chunk label constants and the PCM format code.
// ---------------------------------------------------------------------------
`default_nettype none

package rcs_pkg;

  localparam int unsigned LabelBytes = 4;

  localparam logic [31:0] TagRiff = 32'h5249_4646;
  localparam logic [31:0] TagFmt  = 32'h666D_7420;
  localparam logic [31:0] TagData = 32'h6461_7461;
  localparam logic [15:0] PcmCode = 16'd1;

  typedef enum logic [3:0] {
    EV_FMT      = 4'd0,
    EV_DATA     = 4'd1,
    EV_OTHER    = 4'd2,
    EV_NOT_RIFF = 4'd3,
    EV_ZERO     = 4'd4,
    EV_NO_DATA  = 4'd5,
    EV_NO_FMT   = 4'd6,
    EV_OK_PCM   = 4'd7,
    EV_OK_OTHER = 4'd8
  } event_kind_e;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    event_kind_e event_kind;
    logic [31:0] chunk_offset;
    logic [31:0] chunk_size;
    logic [15:0] format_code;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  r0;
    out_item_t  r1;
  } res_push_t;

endpackage

`default_nettype wire

// ----- sv/riff_chunk_scanner.sv -----
// ---------------------------------------------------------------------------
// riff_chunk_scanner: byte-serial RIFF/WAVE chunk scanner
// Feed a WAVE file one byte per input item, end_of_file set on the last byte.
// Input channel: in_valid_i / in_ready_o with in_item_i (file_byte,
// end_of_file). Output channel: out_valid_o / out_ready_i with out_item_o,
// one event per item; last_result marks the final event caused by a byte.
// A byte causes zero, one or two events. Events of a byte are written to the
// queue as the byte is accepted and leave it in order behind earlier ones.
// Throughput: one byte per cycle while the result queue has room for two
// events; the queue depth (OUT_DEPTH, at least 2) sets how long bytes keep
// flowing while the receiver stalls. When fewer than two slots are free,
// in_ready_o drops until the receiver drains events.
// Reset clears the scan state and empties the queue; after the last byte
// of a file the scanner rearms for the next file on its own.
// ---------------------------------------------------------------------------
`default_nettype none

module riff_chunk_scanner #(
  parameter int unsigned OUT_DEPTH = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire rcs_pkg::in_item_t in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output rcs_pkg::out_item_t     out_item_o
);
  import rcs_pkg::*;

  logic      acc;
  logic      room;
  res_push_t push;

  assign in_ready_o = room;
  assign acc        = in_valid_i && room;

  rcs_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .item_i (in_item_i),
    .push_o (push)
  );

  rcs_res_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ----- sv/rcs_parser.sv -----
// ---------------------------------------------------------------------------
// rcs_parser: chunk walk state and per-byte result logic
// Holds the scan state, updates it on each accepted item and builds the up
// to two result items that the byte causes.
// ---------------------------------------------------------------------------
`default_nettype none

module rcs_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              acc_i,
  input  wire rcs_pkg::in_item_t item_i,
  output rcs_pkg::res_push_t     push_o
);
  import rcs_pkg::*;

  localparam logic [2:0] PH_RIFF_LABEL = 3'd0;
  localparam logic [2:0] PH_RIFF_REST  = 3'd1;
  localparam logic [2:0] PH_HEADER     = 3'd2;
  localparam logic [2:0] PH_FIRST      = 3'd3;
  localparam logic [2:0] PH_SKIP       = 3'd4;

  logic [31:0] pos_q, pos_d;
  logic [2:0]  phase_q, phase_d;
  logic [31:0] label_q, label_d;
  logic [31:0] size_q, size_d;
  logic [31:0] skip_q, skip_d;
  logic [31:0] hdr_q, hdr_d;
  logic        in_fmt_q, in_fmt_d;
  logic [1:0]  taken_q, taken_d;
  logic [15:0] fmt_q, fmt_d;
  logic        fmt_seen_q, fmt_seen_d;
  logic        data_seen_q, data_seen_d;
  logic        halted_q, halted_d;

  logic [31:0] rel;
  logic [7:0]  b;
  out_item_t   ev;
  res_push_t   push;

  always_comb begin
    pos_d       = pos_q;
    phase_d     = phase_q;
    label_d     = label_q;
    size_d      = size_q;
    skip_d      = skip_q;
    hdr_d       = hdr_q;
    in_fmt_d    = in_fmt_q;
    taken_d     = taken_q;
    fmt_d       = fmt_q;
    fmt_seen_d  = fmt_seen_q;
    data_seen_d = data_seen_q;
    halted_d    = halted_q;
    push        = '0;
    ev          = '0;
    b           = item_i.file_byte;
    rel         = pos_q - hdr_q;

    if (!halted_q) begin
      if (in_fmt_q && taken_q == 2'd1) begin
        fmt_d    = {b, fmt_q[7:0]};
        taken_d  = 2'd2;
        in_fmt_d = 1'b0;
      end
      unique case (phase_q)
        PH_RIFF_LABEL: begin
          label_d = {label_q[23:0], b};
          if (pos_q == 32'(LabelBytes - 1)) begin
            if (label_d != TagRiff) begin
              ev            = '0;
              ev.event_kind = EV_NOT_RIFF;
              push.r0       = ev;
              push.cnt      = 2'd1;
              halted_d      = 1'b1;
            end else begin
              phase_d = PH_RIFF_REST;
            end
          end
        end
        PH_RIFF_REST: begin
          if (pos_q == 32'(3 * LabelBytes - 1)) begin
            phase_d = PH_HEADER;
            hdr_d   = pos_q + 32'd1;
            label_d = '0;
            size_d  = '0;
          end
        end
        PH_HEADER: begin
          if (rel < 32'(LabelBytes)) begin
            label_d = {label_q[23:0], b};
          end else begin
            size_d = {b, size_q[31:8]};
          end
          if (rel >= 32'(LabelBytes + 3)) begin
            phase_d = PH_FIRST;
          end
        end
        PH_FIRST: begin
          ev              = '0;
          ev.event_kind   = EV_OTHER;
          ev.chunk_offset = hdr_q;
          ev.chunk_size   = size_q;
          if (label_q == TagFmt) begin
            ev.event_kind = EV_FMT;
            fmt_seen_d    = 1'b1;
            in_fmt_d      = 1'b1;
            taken_d       = 2'd1;
            fmt_d         = {8'h00, b};
          end else if (label_q == TagData) begin
            ev.event_kind = EV_DATA;
            data_seen_d   = 1'b1;
          end
          push.r0  = ev;
          push.cnt = 2'd1;
          if (size_q == 32'd0) begin
            ev.event_kind = EV_ZERO;
            push.r1       = ev;
            push.cnt      = 2'd2;
            halted_d      = 1'b1;
          end else begin
            skip_d = size_q - 32'd1;
            if (skip_d == 32'd0) begin
              phase_d = PH_HEADER;
              hdr_d   = pos_q + 32'd1;
              label_d = '0;
              size_d  = '0;
            end else begin
              phase_d = PH_SKIP;
            end
          end
        end
        default: begin
          skip_d = skip_q - 32'd1;
          if (skip_d == 32'd0) begin
            phase_d = PH_HEADER;
            hdr_d   = pos_q + 32'd1;
            label_d = '0;
            size_d  = '0;
          end
        end
      endcase
    end
    pos_d = pos_q + 32'd1;

    if (item_i.end_of_file) begin
      if (!halted_d) begin
        ev = '0;
        if (phase_d == PH_RIFF_LABEL) begin
          ev.event_kind = EV_NOT_RIFF;
        end else begin
          ev.format_code = fmt_d;
          if (!data_seen_d) begin
            ev.event_kind = EV_NO_DATA;
          end else if (!fmt_seen_d) begin
            ev.event_kind = EV_NO_FMT;
          end else if (fmt_d == PcmCode) begin
            ev.event_kind = EV_OK_PCM;
          end else begin
            ev.event_kind = EV_OK_OTHER;
          end
        end
        if (push.cnt == 2'd0) begin
          push.r0  = ev;
          push.cnt = 2'd1;
        end else begin
          push.r1  = ev;
          push.cnt = 2'd2;
        end
      end
      pos_d       = '0;
      phase_d     = PH_RIFF_LABEL;
      label_d     = '0;
      size_d      = '0;
      skip_d      = '0;
      hdr_d       = '0;
      in_fmt_d    = 1'b0;
      taken_d     = '0;
      fmt_d       = '0;
      fmt_seen_d  = 1'b0;
      data_seen_d = 1'b0;
      halted_d    = 1'b0;
    end

    if (push.cnt == 2'd1) begin
      push.r0.last_result = 1'b1;
    end else if (push.cnt == 2'd2) begin
      push.r1.last_result = 1'b1;
    end
    if (!acc_i) begin
      push.cnt = 2'd0;
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      phase_q     <= PH_RIFF_LABEL;
      label_q     <= '0;
      size_q      <= '0;
      skip_q      <= '0;
      hdr_q       <= '0;
      in_fmt_q    <= 1'b0;
      taken_q     <= '0;
      fmt_q       <= '0;
      fmt_seen_q  <= 1'b0;
      data_seen_q <= 1'b0;
      halted_q    <= 1'b0;
    end else if (acc_i) begin
      pos_q       <= pos_d;
      phase_q     <= phase_d;
      label_q     <= label_d;
      size_q      <= size_d;
      skip_q      <= skip_d;
      hdr_q       <= hdr_d;
      in_fmt_q    <= in_fmt_d;
      taken_q     <= taken_d;
      fmt_q       <= fmt_d;
      fmt_seen_q  <= fmt_seen_d;
      data_seen_q <= data_seen_d;
      halted_q    <= halted_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/rcs_res_fifo.sv -----
// ---------------------------------------------------------------------------
// rcs_res_fifo: result queue
// Takes up to two result items per cycle and hands out one per cycle while the receiver is ready.
// ---------------------------------------------------------------------------
`default_nettype none

module rcs_res_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rcs_pkg::res_push_t push_i,
  output logic                    room_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output rcs_pkg::out_item_t      out_item_o
);
  import rcs_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  out_item_t         mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, wr_ptr_p1, wr_ptr_p2;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              pop;

  assign wr_ptr_p1 = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
  assign wr_ptr_p2 = (wr_ptr_p1 == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_p1 + 1'b1;

  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign room_o      = (cnt_q <= CntW'(DEPTH - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i.cnt == 2'd1) begin
      wr_ptr_d = wr_ptr_p1;
    end else if (push_i.cnt == 2'd2) begin
      wr_ptr_d = wr_ptr_p2;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CntW'(push_i.cnt) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_p1] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top: testbench for the RIFF chunk scanner
// Feeds byte streams shaped as WAVE files (well-formed, cut short, broken or
// plain noise) through the valid/ready input channel. A scan model in the
// testbench predicts the events of every accepted item, and each event that
// leaves the scanner is checked field by field against the oldest prediction.
// Sender and receiver idle at random in two of three phases; the third runs without idling.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rcs_pkg::*;

  localparam int          StallLimit   = 4000;
  localparam int          DrainCycles  = 8;
  localparam logic [31:0] ForeignLabel = 32'h5249_4658;
  localparam logic [31:0] WaveLabel    = 32'h5741_5645;

  typedef enum logic [2:0] {
    SCAN_RIFF_LABEL,
    SCAN_RIFF_REST,
    SCAN_HEADER,
    SCAN_FIRST,
    SCAN_SKIP
  } scan_phase_e;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  riff_chunk_scanner dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  out_item_t   expected_events[$];
  logic [7:0]  file_bytes[$];
  int          error_count;
  int          bytes_sent;
  int          sender_idle_pct;
  int          receiver_idle_pct;

  // scan model state
  logic [31:0] byte_pos;
  scan_phase_e phase;
  logic [31:0] label_acc;
  logic [31:0] size_acc;
  logic [31:0] bytes_left;
  logic [31:0] chunk_start;
  logic        in_fmt;
  logic [1:0]  fmt_taken;
  logic [15:0] fmt_code;
  logic        fmt_found;
  logic        data_found;
  logic        scan_halted;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_idle_pct);
  end

  function automatic void clear_scan_state();
    byte_pos    = '0;
    phase       = SCAN_RIFF_LABEL;
    label_acc   = '0;
    size_acc    = '0;
    bytes_left  = '0;
    chunk_start = '0;
    in_fmt      = 1'b0;
    fmt_taken   = '0;
    fmt_code    = '0;
    fmt_found   = 1'b0;
    data_found  = 1'b0;
    scan_halted = 1'b0;
  endfunction

  function automatic void start_header(input logic [31:0] at);
    phase       = SCAN_HEADER;
    chunk_start = at;
    label_acc   = '0;
    size_acc    = '0;
  endfunction

  function automatic out_item_t make_event(input event_kind_e kind, input logic [31:0] offset,
                                           input logic [31:0] size, input logic [15:0] code);
    out_item_t ev;
    ev.event_kind   = kind;
    ev.chunk_offset = offset;
    ev.chunk_size   = size;
    ev.format_code  = code;
    ev.last_result  = 1'b0;
    return ev;
  endfunction

  task automatic predict_scan_events(input in_item_t item);
    logic [7:0]  b;
    logic [31:0] rel;
    event_kind_e kind;
    out_item_t   evs[2];
    int          n;
    b = item.file_byte;
    n = 0;
    if (!scan_halted) begin
      if (in_fmt && fmt_taken == 2'd1) begin
        fmt_code  = {b, fmt_code[7:0]};
        fmt_taken = 2'd2;
        in_fmt    = 1'b0;
      end
      case (phase)
        SCAN_RIFF_LABEL: begin
          label_acc = {label_acc[23:0], b};
          if (byte_pos == LabelBytes - 1) begin
            if (label_acc != TagRiff) begin
              evs[n] = make_event(EV_NOT_RIFF, '0, '0, '0);
              n++;
              scan_halted = 1'b1;
            end else begin
              phase = SCAN_RIFF_REST;
            end
          end
        end
        SCAN_RIFF_REST: begin
          if (byte_pos == 3 * LabelBytes - 1) start_header(byte_pos + 1);
        end
        SCAN_HEADER: begin
          rel = byte_pos - chunk_start;
          if (rel < LabelBytes) label_acc = {label_acc[23:0], b};
          else size_acc = {b, size_acc[31:8]};
          if (rel >= LabelBytes + 3) phase = SCAN_FIRST;
        end
        SCAN_FIRST: begin
          kind = EV_OTHER;
          if (label_acc == TagFmt) begin
            kind      = EV_FMT;
            fmt_found = 1'b1;
            in_fmt    = 1'b1;
            fmt_taken = 2'd1;
            fmt_code  = {8'h00, b};
          end else if (label_acc == TagData) begin
            kind       = EV_DATA;
            data_found = 1'b1;
          end
          evs[n] = make_event(kind, chunk_start, size_acc, '0);
          n++;
          if (size_acc == '0) begin
            evs[n] = make_event(EV_ZERO, chunk_start, size_acc, '0);
            n++;
            scan_halted = 1'b1;
          end else begin
            bytes_left = size_acc - 1;
            if (bytes_left == '0) start_header(byte_pos + 1);
            else phase = SCAN_SKIP;
          end
        end
        default: begin
          bytes_left = bytes_left - 1;
          if (bytes_left == '0) start_header(byte_pos + 1);
        end
      endcase
    end
    byte_pos = byte_pos + 1;
    if (item.end_of_file) begin
      if (!scan_halted) begin
        if (phase == SCAN_RIFF_LABEL) begin
          evs[n] = make_event(EV_NOT_RIFF, '0, '0, '0);
        end else begin
          kind = !data_found ? EV_NO_DATA :
                 !fmt_found ? EV_NO_FMT :
                 (fmt_code == PcmCode) ? EV_OK_PCM : EV_OK_OTHER;
          evs[n] = make_event(kind, '0, '0, fmt_code);
        end
        n++;
      end
      clear_scan_state();
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) evs[i].last_result = 1'b1;
      expected_events.push_back(evs[i]);
    end
  endtask

  function automatic int field_differs(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i) begin : event_check
    out_item_t want;
    int        bad;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_events.size() == 0) begin
        $display("%0t: expected no event, got kind %0d offset %0h size %0h code %0h last %0b",
                 $time, out_item_o.event_kind, out_item_o.chunk_offset,
                 out_item_o.chunk_size, out_item_o.format_code, out_item_o.last_result);
        error_count++;
      end else begin
        want = expected_events.pop_front();
        bad  = field_differs("event_kind", 32'(want.event_kind), 32'(out_item_o.event_kind));
        bad += field_differs("chunk_offset", want.chunk_offset, out_item_o.chunk_offset);
        bad += field_differs("chunk_size", want.chunk_size, out_item_o.chunk_size);
        bad += field_differs("format_code", 32'(want.format_code), 32'(out_item_o.format_code));
        bad += field_differs("last_result", 32'(want.last_result), 32'(out_item_o.last_result));
        if (bad != 0) error_count++;
      end
    end
  end

  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stalled = 0;
      else stalled++;
    end
    $display("%0t: no item accepted for %0d cycles", $time, StallLimit);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_byte(input logic [7:0] value, input logic last);
    in_item_t item;
    item.file_byte   = value;
    item.end_of_file = last;
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    predict_scan_events(item);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++) begin
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
    end
  endtask

  function automatic void append_label(input logic [31:0] label);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(label[8*i +: 8]);
  endfunction

  function automatic void append_le32(input logic [31:0] value);
    for (int i = 0; i < 4; i++) file_bytes.push_back(value[8*i +: 8]);
  endfunction

  // mostly well-formed files with random chunk content; the rest noise or broken
  function automatic void build_random_file();
    int          shape;
    int          chunks_left;
    int          pick;
    int          body;
    int          keep;
    logic [31:0] label;
    logic [31:0] chunk_size;
    file_bytes.delete();
    shape = $urandom_range(99);
    if (shape < 10) begin
      repeat ($urandom_range(1, 12)) file_bytes.push_back(8'($urandom_range(255)));
    end else begin
      if (shape < 15) append_label({TagRiff[31:8], 8'($urandom_range(255))});
      else append_label(TagRiff);
      append_le32($urandom);
      append_label(($urandom_range(3) == 0) ? 32'($urandom) : WaveLabel);
      chunks_left = $urandom_range(0, 4);
      while (chunks_left > 0) begin
        pick = $urandom_range(99);
        if (pick < 35) label = TagFmt;
        else if (pick < 70) label = TagData;
        else if (pick < 80) label = {TagFmt[31:8], 8'($urandom_range(255))};
        else label = $urandom;
        pick = $urandom_range(99);
        if (pick < 6) chunk_size = '0;
        else if (pick < 16) chunk_size = 32'd1;
        else if (pick < 22) chunk_size = $urandom;
        else chunk_size = $urandom_range(2, 24);
        append_label(label);
        append_le32(chunk_size);
        // cut the file inside any chunk too big to walk through
        body = (chunk_size > 32) ? $urandom_range(0, 16) : int'(chunk_size);
        chunks_left = (chunk_size > 32) ? 0 : chunks_left - 1;
        for (int k = 0; k < body; k++) begin
          if (label == TagFmt && k < 2 && $urandom_range(1) == 1)
            file_bytes.push_back((k == 0) ? 8'h01 : 8'h00);
          else
            file_bytes.push_back(8'($urandom_range(255)));
        end
      end
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 6)) file_bytes.push_back(8'($urandom_range(255)));
      end
      if ($urandom_range(4) == 0) begin
        keep = $urandom_range(1, file_bytes.size());
        while (file_bytes.size() > keep) void'(file_bytes.pop_back());
      end
    end
  endfunction

  task automatic test_foreign_files();
    file_bytes.delete();
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'h52);
    send_file();
    file_bytes.delete();
    append_label(ForeignLabel);
    file_bytes.push_back(8'hA5);
    send_file();
  endtask

  task automatic test_headerless_riff();
    file_bytes.delete();
    append_label(TagRiff);
    append_le32(32'hFFFF_FFFF);
    append_le32(32'h0000_0000);
    file_bytes.push_back(8'h66);
    send_file();
  endtask

  task automatic test_random_files(input int send_pct, input int recv_pct, input int byte_goal);
    int start;
    sender_idle_pct   = send_pct;
    receiver_idle_pct = recv_pct;
    start = bytes_sent;
    while (bytes_sent - start < byte_goal) begin
      build_random_file();
      send_file();
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    in_item_i         = '0;
    out_ready_i       = 1'b0;
    error_count       = 0;
    bytes_sent        = 0;
    sender_idle_pct   = 15;
    receiver_idle_pct = 74;
    clear_scan_state();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_foreign_files();
    test_headerless_riff();
    test_random_files(15, 74, 330);
    test_random_files(74, 15, 330);
    test_random_files(0, 0, 340);

    in_valid_i <= 1'b0;
    while (expected_events.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
